// File: rtl/awf_pkg.sv
// Shared types and constants for the anagram window finder.
// Used by every module of the block except awf_ram; depends on nothing else.
`timescale 1ns / 1ps

package awf_pkg;

   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 32;
   localparam int OP_W      = 2;
   localparam int CHAR_NUM  = 256;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ITEM_NONE    = 2'd0,
      ITEM_CLEAR   = 2'd1,
      ITEM_PATTERN = 2'd2,
      ITEM_TEXT    = 2'd3
   } item_kind_type;

   typedef struct packed {
      item_kind_type       kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   leave_byte;
      logic                leave;
      logic [INDEX_W-1:0]  win_start;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [INDEX_W-1:0]  start_index;
   } result_type;

endpackage

// File: rtl/awf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; holds the count tables and the window ring.
`timescale 1ns / 1ps

module awf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/awf_ctrl.sv
// Front stage: decodes transactions, keeps the pattern length, text and window
// positions and the window ring. Depends on awf_pkg and awf_ram.
`timescale 1ns / 1ps

module awf_ctrl #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [awf_pkg::OP_W-1:0]      op,
   input  logic [awf_pkg::BYTE_W-1:0]    data_byte,
   output awf_pkg::item_type             item
);

   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CMP_W  = LEN_W + 1;

   logic [LEN_W-1:0]               pattern_len_ff, pattern_len_in;
   logic                           text_seen_ff, text_seen_in;
   logic [SLOT_W-1:0]              ring_slot_ff, ring_slot_in;
   logic [awf_pkg::INDEX_W-1:0]    text_pos_ff, text_pos_in;
   logic [awf_pkg::INDEX_W-1:0]    window_start_ff, window_start_in;

   awf_pkg::item_kind_type         s1_kind_ff, s1_kind_in;
   logic [awf_pkg::BYTE_W-1:0]     s1_byte_ff;
   logic                           s1_leave_ff, s1_leave_in;
   logic                           s1_same_ff;
   logic [awf_pkg::INDEX_W-1:0]    s1_start_ff;

   logic [CMP_W-1:0]               slot_next_wide;
   logic [SLOT_W-1:0]              leave_slot;
   logic                           window_full;
   logic                           ring_we;
   logic [awf_pkg::BYTE_W-1:0]     ring_rd;

   assign slot_next_wide = CMP_W'(ring_slot_ff) + CMP_W'(1);
   assign leave_slot     = (slot_next_wide >= CMP_W'(pattern_len_ff)) ? '0
                         : slot_next_wide[SLOT_W-1:0];
   assign window_full    = (text_pos_ff - window_start_ff)
                         == (awf_pkg::INDEX_W'(pattern_len_ff) - awf_pkg::INDEX_W'(1));

   always_comb begin
      pattern_len_in  = pattern_len_ff;
      text_seen_in    = text_seen_ff;
      ring_slot_in    = ring_slot_ff;
      text_pos_in     = text_pos_ff;
      window_start_in = window_start_ff;
      s1_kind_in      = awf_pkg::ITEM_NONE;
      s1_leave_in     = 1'b0;
      ring_we         = 1'b0;
      if (accept) begin
         unique case (awf_pkg::op_type'(op))
            awf_pkg::OP_CLEAR: begin
               pattern_len_in  = '0;
               text_seen_in    = 1'b0;
               ring_slot_in    = '0;
               text_pos_in     = '0;
               window_start_in = '0;
               s1_kind_in      = awf_pkg::ITEM_CLEAR;
            end
            awf_pkg::OP_PATTERN: begin
               if (!text_seen_ff && (pattern_len_ff < LEN_W'(MAX_PATTERN))) begin
                  pattern_len_in = pattern_len_ff + LEN_W'(1);
                  s1_kind_in     = awf_pkg::ITEM_PATTERN;
               end
            end
            awf_pkg::OP_TEXT: begin
               text_seen_in = 1'b1;
               text_pos_in  = text_pos_ff + awf_pkg::INDEX_W'(1);
               if (pattern_len_ff != '0) begin
                  s1_kind_in   = awf_pkg::ITEM_TEXT;
                  s1_leave_in  = window_full;
                  ring_we      = 1'b1;
                  ring_slot_in = leave_slot;
                  if (window_full) begin
                     window_start_in = window_start_ff + awf_pkg::INDEX_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= '0;
         text_seen_ff    <= 1'b0;
         ring_slot_ff    <= '0;
         text_pos_ff     <= '0;
         window_start_ff <= '0;
         s1_kind_ff      <= awf_pkg::ITEM_NONE;
      end else begin
         pattern_len_ff  <= pattern_len_in;
         text_seen_ff    <= text_seen_in;
         ring_slot_ff    <= ring_slot_in;
         text_pos_ff     <= text_pos_in;
         window_start_ff <= window_start_in;
         s1_kind_ff      <= s1_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= data_byte;
      s1_leave_ff <= s1_leave_in;
      s1_same_ff  <= (leave_slot == ring_slot_ff);
      s1_start_ff <= window_start_ff;
   end

   // With a one-byte pattern the leaving byte is the one just written.
   awf_ram #(
      .WIDTH (awf_pkg::BYTE_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_slot_ff),
      .wr_data (data_byte),
      .rd_addr (leave_slot),
      .rd_data (ring_rd)
   );

   assign item.kind       = s1_kind_ff;
   assign item.data_byte  = s1_byte_ff;
   assign item.leave_byte = s1_same_ff ? s1_byte_ff : ring_rd;
   assign item.leave      = s1_leave_ff;
   assign item.win_start  = s1_start_ff;

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      (text_seen_ff && pattern_len_ff != '0)
         |-> (CMP_W'(ring_slot_ff) < CMP_W'(pattern_len_ff)))
      else $error("ring slot outside the pattern length");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      $past(accept) |-> (pattern_len_ff <= LEN_W'(MAX_PATTERN)))
      else $error("pattern length beyond its maximum");

endmodule

// File: rtl/awf_count.sv
// Count engine: reads, updates and writes back the per-character count tables
// and tracks matched and distinct characters. Depends on awf_pkg and awf_ram.
`timescale 1ns / 1ps

module awf_count #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  awf_pkg::item_type    item,
   output awf_pkg::result_type  result,
   output logic                 busy
);

   localparam int CW    = $clog2(MAX_PATTERN + 1) + 1;
   localparam int AWORD = CW + 1;
   localparam int DW    = $clog2(((MAX_PATTERN < awf_pkg::CHAR_NUM) ? MAX_PATTERN
                                  : awf_pkg::CHAR_NUM) + 1);

   // Table A holds the pattern membership bit over pattern count minus bytes
   // entered; table B holds bytes that have left. Their sum is the live count.
   // Each pattern byte zeroes its table B entry, so the table A valid bits
   // cover both tables.
   logic [awf_pkg::CHAR_NUM-1:0]   a_valid_ff, a_valid_in;
   logic [DW-1:0]                  matched_ff, matched_in;
   logic [DW-1:0]                  distinct_ff, distinct_in;

   awf_pkg::item_kind_type         s2_kind_ff;
   logic [awf_pkg::BYTE_W-1:0]     s2_byte_ff, s2_lbyte_ff;
   logic                           s2_leave_ff;
   logic [awf_pkg::INDEX_W-1:0]    s2_start_ff;
   logic                           s2_va_b_ff, s2_va_c_ff;

   logic                           fa_valid_ff, fb_valid_ff;
   logic [awf_pkg::BYTE_W-1:0]     fa_addr_ff, fb_addr_ff;
   logic [AWORD-1:0]               fa_data_ff;
   logic [CW-1:0]                  fb_data_ff;

   logic                           clr_now;
   logic [AWORD-1:0]               a_entry_rd, a_leave_rd;
   logic [CW-1:0]                  b_entry_rd, b_leave_rd;
   logic [AWORD-1:0]               a_b_word, a_c_word, a_c_eff, a_wdata;
   logic [CW-1:0]                  b_b_cnt, b_c_cnt, b_wdata, cnt_b, cnt_c;
   logic [awf_pkg::BYTE_W-1:0]     b_waddr;
   logic                           a_we, b_we, emit;
   logic [DW-1:0]                  m1;

   assign clr_now = (s2_kind_ff == awf_pkg::ITEM_CLEAR);
   assign busy    = (s2_kind_ff != awf_pkg::ITEM_NONE);

   awf_ram #(.WIDTH(AWORD), .DEPTH(awf_pkg::CHAR_NUM)) u_a_entry (
      .clock (clock), .wr_en (a_we), .wr_addr (s2_byte_ff), .wr_data (a_wdata),
      .rd_addr (item.data_byte), .rd_data (a_entry_rd)
   );

   awf_ram #(.WIDTH(AWORD), .DEPTH(awf_pkg::CHAR_NUM)) u_a_leave (
      .clock (clock), .wr_en (a_we), .wr_addr (s2_byte_ff), .wr_data (a_wdata),
      .rd_addr (item.leave_byte), .rd_data (a_leave_rd)
   );

   awf_ram #(.WIDTH(CW), .DEPTH(awf_pkg::CHAR_NUM)) u_b_entry (
      .clock (clock), .wr_en (b_we), .wr_addr (b_waddr), .wr_data (b_wdata),
      .rd_addr (item.data_byte), .rd_data (b_entry_rd)
   );

   awf_ram #(.WIDTH(CW), .DEPTH(awf_pkg::CHAR_NUM)) u_b_leave (
      .clock (clock), .wr_en (b_we), .wr_addr (b_waddr), .wr_data (b_wdata),
      .rd_addr (item.leave_byte), .rd_data (b_leave_rd)
   );

   always_comb begin
      a_b_word = s2_va_b_ff ? a_entry_rd : '0;
      if (fa_valid_ff && fa_addr_ff == s2_byte_ff) begin
         a_b_word = fa_data_ff;
      end
      a_c_word = s2_va_c_ff ? a_leave_rd : '0;
      if (fa_valid_ff && fa_addr_ff == s2_lbyte_ff) begin
         a_c_word = fa_data_ff;
      end
      b_b_cnt = s2_va_b_ff ? b_entry_rd : '0;
      if (fb_valid_ff && fb_addr_ff == s2_byte_ff) begin
         b_b_cnt = fb_data_ff;
      end
      b_c_cnt = s2_va_c_ff ? b_leave_rd : '0;
      if (fb_valid_ff && fb_addr_ff == s2_lbyte_ff) begin
         b_c_cnt = fb_data_ff;
      end

      a_we        = 1'b0;
      b_we        = 1'b0;
      a_wdata     = a_b_word;
      b_wdata     = b_c_cnt;
      b_waddr     = s2_lbyte_ff;
      a_c_eff     = a_c_word;
      cnt_b       = '0;
      cnt_c       = '0;
      m1          = matched_ff;
      emit        = 1'b0;
      matched_in  = matched_ff;
      distinct_in = distinct_ff;
      a_valid_in  = a_valid_ff;

      unique case (s2_kind_ff)
         awf_pkg::ITEM_CLEAR: begin
            a_valid_in  = '0;
            matched_in  = '0;
            distinct_in = '0;
         end
         awf_pkg::ITEM_PATTERN: begin
            a_we        = 1'b1;
            a_wdata     = {1'b1, a_b_word[CW-1:0] + CW'(1)};
            distinct_in = distinct_ff + DW'(!a_b_word[CW]);
            b_we        = 1'b1;
            b_waddr     = s2_byte_ff;
            b_wdata     = '0;
         end
         awf_pkg::ITEM_TEXT: begin
            cnt_b   = a_b_word[CW-1:0] + b_b_cnt - CW'(1);
            a_we    = a_b_word[CW];
            a_wdata = {1'b1, a_b_word[CW-1:0] - CW'(1)};
            m1      = matched_ff + DW'(a_we && cnt_b == '0);
            emit    = (m1 == distinct_ff);
            // The leaving byte sees the entering byte's decrement first.
            if (a_we && s2_lbyte_ff == s2_byte_ff) begin
               a_c_eff = a_wdata;
            end
            cnt_c      = a_c_eff[CW-1:0] + b_c_cnt;
            matched_in = m1;
            if (s2_leave_ff && a_c_eff[CW]) begin
               b_we       = 1'b1;
               b_wdata    = b_c_cnt + CW'(1);
               matched_in = m1 - DW'(cnt_c == '0);
            end
         end
         default: begin
         end
      endcase

      if (a_we) begin
         a_valid_in[s2_byte_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= '0;
         matched_ff  <= '0;
         distinct_ff <= '0;
         s2_kind_ff  <= awf_pkg::ITEM_NONE;
         fa_valid_ff <= 1'b0;
         fb_valid_ff <= 1'b0;
      end else begin
         a_valid_ff  <= a_valid_in;
         matched_ff  <= matched_in;
         distinct_ff <= distinct_in;
         s2_kind_ff  <= item.kind;
         fa_valid_ff <= a_we;
         fb_valid_ff <= b_we;
      end
   end

   always_ff @(posedge clock) begin
      s2_byte_ff  <= item.data_byte;
      s2_lbyte_ff <= item.leave_byte;
      s2_leave_ff <= item.leave;
      s2_start_ff <= item.win_start;
      s2_va_b_ff  <= a_valid_ff[item.data_byte]  && !clr_now;
      s2_va_c_ff  <= a_valid_ff[item.leave_byte] && !clr_now;
      fa_addr_ff  <= s2_byte_ff;
      fa_data_ff  <= a_wdata;
      fb_addr_ff  <= b_waddr;
      fb_data_ff  <= b_wdata;
   end

   assign result.valid       = emit;
   assign result.start_index = s2_start_ff;

   a_matched_bounded: assert property (@(posedge clock) disable iff (reset)
      matched_ff <= distinct_ff)
      else $error("more matched characters than distinct pattern characters");

endmodule

// File: rtl/awf_rsp_q.sv
// Result queue: holds start indices until the receiver takes them and tells
// the front whether a new transaction may enter. Depends on awf_pkg.
`timescale 1ns / 1ps

module awf_rsp_q (
   input  logic                           clock,
   input  logic                           reset,
   input  awf_pkg::result_type            result,
   input  logic [1:0]                     pend,
   output logic                           accept_ok,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [awf_pkg::INDEX_W-1:0]    rsp_tdata
);

   localparam int CNT_W = awf_pkg::RSP_AW + 1;

   logic [awf_pkg::INDEX_W-1:0] data_ff [awf_pkg::RSP_DEPTH];
   logic [awf_pkg::RSP_AW-1:0]  head_ff, head_in;
   logic [awf_pkg::RSP_AW-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        push, pop;

   assign push = result.valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      head_in  = pop  ? head_ff + awf_pkg::RSP_AW'(1) : head_ff;
      tail_in  = push ? tail_ff + awf_pkg::RSP_AW'(1) : tail_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[tail_ff] <= result.start_index;
      end
   end

   // Every transaction still in the pipeline may yet produce a result.
   assign accept_ok  = (count_ff + CNT_W'(pend)) < CNT_W'(awf_pkg::RSP_DEPTH);
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = data_ff[head_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(awf_pkg::RSP_DEPTH)))
      else $error("result pushed into a full queue");

endmodule

// File: rtl/anagram_window_finder_unit.sv
// Top level of the anagram window finder.
// Depends on awf_pkg, awf_ctrl, awf_count, awf_rsp_q and awf_ram.
//
// Each transaction on the req_ side carries a kind in req_tuser (clear, pattern
// byte or text byte) and a byte in req_tdata. Pattern bytes build the character
// counts of the pattern; text bytes slide a window of pattern length over the
// text. Whenever the window holds an anagram of the pattern, the start index of
// that window is sent on the rsp_ side as one transaction.
// One transaction is accepted every cycle while req_tready is high. A result
// reaches the rsp_ side through the window ring read, the count table read
// and the update with the write into the result queue, each registered.
// Count updates of back-to-back bytes are forwarded from the previous write,
// so no bubbles are needed.
// If the receiver stalls, results wait in a four-entry queue; req_tready falls
// once the queue together with the transactions still in flight could fill it.
// Reset, and a clear transaction, empty the count tables at once by clearing
// their valid bits; there is no clearing pass and the block is ready in the
// cycle after reset.
`timescale 1ns / 1ps

module anagram_window_finder_unit #(
   parameter int MAX_PATTERN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] start_index
);

   logic                 accept;
   logic                 s2_busy;
   logic [1:0]           pend;
   awf_pkg::item_type    item;
   awf_pkg::result_type  result;

   assign accept = req_tvalid && req_tready;
   assign pend   = 2'(item.kind != awf_pkg::ITEM_NONE) + 2'(s2_busy);

   awf_ctrl #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_tuser),
      .data_byte (req_tdata),
      .item      (item)
   );

   awf_count #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_count (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .result (result),
      .busy   (s2_busy)
   );

   awf_rsp_q u_rsp_q (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .pend       (pend),
      .accept_ok  (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
